// ===== hw/rtl/open_addressing_hash_table_assert.svh =====
// assertion macros for the open addressing hash table
`ifndef OPEN_ADDRESSING_HASH_TABLE_ASSERT_SVH
`define OPEN_ADDRESSING_HASH_TABLE_ASSERT_SVH

`ifndef ASSERT_OFF

`define OHT_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

`define OHT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define OHT_ASSERT(lbl, clk, rst, prop)

`define OHT_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== hw/rtl/ohash_pkg.sv =====
// shared constants and types of the open addressing hash table
`default_nettype none

package ohash_pkg;

  localparam int INDEX_BITS_DEF   = 10;
  localparam int PRODUCT_BITS_DEF = 20;

  localparam int KEY_W     = 31;
  localparam int SLOT_W    = 10;
  localparam int COUNT_W   = 11;
  localparam int MULT_W    = 20;
  localparam int MODE_W    = 2;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 1;

  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [MODE_W-1:0]   mode_t;

  localparam status_t ST_INSERTED  = 2'd0;
  localparam status_t ST_FOUND     = 2'd1;
  localparam status_t ST_NOT_FOUND = 2'd2;
  localparam status_t ST_FULL      = 2'd3;

  localparam mode_t MODE_LINEAR = 2'd0;
  localparam mode_t MODE_QUAD   = 2'd1;
  localparam mode_t MODE_XOR    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_PROBE_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HASH_MULT  = 1'b1;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

endpackage

`default_nettype wire

// ===== hw/rtl/ohash_ram.sv =====
// generic single write port ram with registered read
`default_nettype none

module ohash_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/open_addressing_hash_table.sv =====
// open addressing hash table with multiplicative hash and configurable probing
//
// requests (req_type, key) come in on req_valid/req_ready, one result
// (status, slot, probe_count) per request goes out on rsp_valid/rsp_ready.
// probe_mode and hash_multiplier are written on cfg_valid/cfg_ready with
// cfg_index 0 and 1; cfg_ready is always high.
// after reset the block sweeps the slot memory once to mark every slot
// empty, and takes no request until then.
// the hash product is registered at the transfer edge; a request then
// registers its home slot (S_HASH), reads the slot memory (S_ADDR) and
// compares (S_CHECK) once per probe, and moves its result from S_DONE into
// the output register, where rsp_valid is set.
// req_ready is high only while no request is at work, so a new request is
// taken only after the last result has gone to the output register.
// a result waits in the output register while the receiver stalls; the next
// request is still taken and worked on, and holds its result until the
// output register frees.
`default_nettype none

module open_addressing_hash_table
  import ohash_pkg::*;
#(
  parameter int INDEX_BITS   = INDEX_BITS_DEF,
  parameter int PRODUCT_BITS = PRODUCT_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 req_valid,
  output logic                      req_ready,
  input  wire logic                 req_type,
  input  wire logic [KEY_W-1:0]     key,
  output logic                      rsp_valid,
  input  wire logic                 rsp_ready,
  output logic [STATUS_W-1:0]       status,
  output logic [SLOT_W-1:0]         slot,
  output logic [COUNT_W-1:0]        probe_count,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [MULT_W-1:0]    cfg_data
);

  localparam int IB     = INDEX_BITS;
  localparam int PB     = PRODUCT_BITS;
  localparam int DEPTH  = 1 << IB;
  localparam int SHR    = (PB >= IB) ? PB - IB : 0;
  localparam int SHL    = (PB >= IB) ? 0 : IB - PB;
  localparam int ENTRY_W = KEY_W + 1;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_HASH  = 3'd2;
  localparam logic [2:0] S_ADDR  = 3'd3;
  localparam logic [2:0] S_CHECK = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]        state;
  mode_t             probe_mode;
  logic [MULT_W-1:0] hash_multiplier;

  logic              req_lookup;
  logic [KEY_W-1:0]  key_r;
  logic [PB-1:0]     prod;
  logic [IB-1:0]     home;
  logic [IB-1:0]     probe_idx;
  logic [IB-1:0]     probe_off;
  logic [IB-1:0]     probe_addr;
  logic [IB-1:0]     off_step;
  logic [IB-1:0]     home_next;
  logic [31:0]       mul_full;

  status_t           res_status;
  logic [SLOT_W-1:0] res_slot;
  logic [COUNT_W-1:0] res_count;

  logic               ram_we;
  logic [IB-1:0]      ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  logic               entry_valid;
  logic               key_match;
  logic               probe_last;
  logic               out_free;
  logic [IB:0]        count_now;

  assign req_ready = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  assign mul_full  = 32'(hash_multiplier) * 32'(key);
  assign home_next = IB'(({{IB{1'b0}}, prod} << SHL) >> SHR);

  always_comb begin
    if (probe_mode == MODE_XOR) begin
      probe_addr = home ^ probe_idx;
    end else begin
      probe_addr = home + probe_off;
    end
    if (probe_mode == MODE_QUAD) begin
      off_step = {probe_idx[IB-2:0], 1'b1};
    end else begin
      off_step = IB'(1);
    end
  end

  assign entry_valid = ram_rdata[KEY_W];
  assign key_match   = (ram_rdata[KEY_W-1:0] == key_r);
  assign probe_last  = &probe_idx;
  assign out_free    = !rsp_valid || rsp_ready;
  assign count_now   = {1'b0, probe_idx} + 1'b1;

  // slot memory writes: empty marks during the sweep, inserts otherwise
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = probe_addr;
    ram_wdata = {1'b1, key_r};
    if (state == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = probe_idx;
      ram_wdata = '0;
    end else if (state == S_CHECK && !entry_valid && !req_lookup) begin
      ram_we = 1'b1;
    end
  end

  ohash_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (probe_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      probe_mode      <= MODE_LINEAR;
      hash_multiplier <= MULT_W'(1);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PROBE_MODE: probe_mode      <= cfg_data[MODE_W-1:0];
        REG_HASH_MULT:  hash_multiplier <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      probe_idx <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (state == S_DONE && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          probe_idx <= probe_idx + 1'b1;
          if (probe_last) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_valid) begin
            req_lookup <= (req_type == REQ_LOOKUP);
            key_r      <= key;
            prod       <= mul_full[PB-1:0];
            state      <= S_HASH;
          end
        end
        S_HASH: begin
          home      <= home_next;
          probe_idx <= '0;
          probe_off <= '0;
          state     <= S_ADDR;
        end
        S_ADDR: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          priority if (!entry_valid) begin
            res_status <= req_lookup ? ST_NOT_FOUND : ST_INSERTED;
            res_slot   <= req_lookup ? '0 : SLOT_W'(probe_addr);
            res_count  <= COUNT_W'(count_now);
            state      <= S_DONE;
          end else if (req_lookup && key_match) begin
            res_status <= ST_FOUND;
            res_slot   <= SLOT_W'(probe_addr);
            res_count  <= COUNT_W'(count_now);
            state      <= S_DONE;
          end else if (probe_last) begin
            res_status <= req_lookup ? ST_NOT_FOUND : ST_FULL;
            res_slot   <= '0;
            res_count  <= COUNT_W'(count_now);
            state      <= S_DONE;
          end else begin
            probe_idx <= probe_idx + 1'b1;
            probe_off <= probe_off + off_step;
            state     <= S_ADDR;
          end
        end
        S_DONE: begin
          if (out_free) begin
            status      <= res_status;
            slot        <= res_slot;
            probe_count <= res_count;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`include "open_addressing_hash_table_assert.svh"

  `OHT_ASSERT(a_write_when_allowed, clk, rst, !ram_we || state == S_CLEAR || state == S_CHECK)
  `OHT_ASSERT(a_lookup_no_write, clk, rst, !(state == S_CHECK && req_lookup && ram_we))
  `OHT_ASSERT_NEXT(a_accept_to_hash, clk, rst, req_valid && req_ready, state == S_HASH)
  `OHT_ASSERT_NEXT(a_done_loads, clk, rst, state == S_DONE && out_free, rsp_valid && state == S_IDLE)

endmodule

`default_nettype wire
